// ----- sv/renc_pkg.sv -----
// Shared types, codes and constants for the rotary encoder detent bank
`timescale 1ns / 1ps

package renc_pkg;

    localparam int NUM_ENCODERS_DEF = 8;
    localparam int INDEX_W          = 3;
    localparam int CLICK_W          = 8;

    localparam logic signed [CLICK_W-1:0] CLICK_MAX = 8'sd127;
    localparam logic signed [CLICK_W-1:0] CLICK_MIN = -8'sd128;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAKE   = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    typedef struct packed {
        logic                      turning;
        logic [1:0]                dir;
        logic signed [CLICK_W-1:0] clicks;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

endpackage

// ----- sv/rotary_encoder_detent_bank.sv -----
// Top level of the rotary encoder detent bank
//
//  channel | beat                                       | valid     | stall
//  --------+--------------------------------------------+-----------+----------
//  event   | kind, encoder_index, level_a, level_b      | evt_valid | evt_stall
//  result  | encoder_clicks, any_active, active_index   | res_valid | res_stall
//
// An event beat goes through two steps: a registered state memory read, then modify and write back.
// A new event is taken only in the idle state, once the previous one has written back.
// Reset clears all encoder state at once through per-entry valid bits.
// A stalled result holds in the output register; one further event is taken and
// waits in the modify step until the output register frees.
`timescale 1ns / 1ps

module rotary_encoder_detent_bank #(
    parameter int NUM_ENCODERS = renc_pkg::NUM_ENCODERS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  evt_valid,
    output logic                                  evt_stall,
    input  logic                                  kind,
    input  logic [renc_pkg::INDEX_W-1:0]          encoder_index,
    input  logic                                  level_a,
    input  logic                                  level_b,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic signed [renc_pkg::CLICK_W-1:0]   encoder_clicks,
    output logic                                  any_active,
    output logic [renc_pkg::INDEX_W-1:0]          active_index
);

    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int EW    = IDX_W + 4;

    renc_pkg::state_t                     state_reg;
    renc_pkg::state_t                     state_next;

    logic                                 evt_accept;
    logic                                 out_load;
    logic                                 wr_en;
    logic [EW-1:0]                        idx_ext;
    logic                                 in_range;

    logic                                 kind_reg;
    logic                                 a_reg;
    logic                                 b_reg;
    logic [IDX_W-1:0]                     addr_reg;
    logic                                 in_range_reg;

    renc_pkg::entry_t                     cur_entry;
    renc_pkg::entry_t                     new_entry;
    logic signed [renc_pkg::CLICK_W-1:0]  reported;
    logic                                 any_next;
    logic [renc_pkg::INDEX_W-1:0]         active_next;

    logic                                 res_valid_reg;
    logic signed [renc_pkg::CLICK_W-1:0]  clicks_reg;
    logic                                 any_reg;
    logic [renc_pkg::INDEX_W-1:0]         active_reg;

    assign idx_ext    = EW'(encoder_index);
    assign in_range   = idx_ext < EW'(NUM_ENCODERS);
    assign evt_accept = evt_valid && !evt_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            renc_pkg::ST_IDLE:
            begin
                if (evt_accept)
                begin
                    state_next = renc_pkg::ST_MODIFY;
                end
            end
            renc_pkg::ST_MODIFY:
            begin
                if (out_load)
                begin
                    state_next = renc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = renc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        evt_stall = 1'b1;
        out_load  = 1'b0;
        unique case (state_reg)
            renc_pkg::ST_IDLE:
            begin
                evt_stall = 1'b0;
            end
            renc_pkg::ST_MODIFY:
            begin
                out_load = !res_valid_reg || !res_stall;
            end
            default:
            begin
                evt_stall = 1'b1;
            end
        endcase
    end

    assign wr_en = out_load && in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= renc_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            kind_reg     <= kind;
            a_reg        <= level_a;
            b_reg        <= level_b;
            addr_reg     <= idx_ext[IDX_W-1:0];
            in_range_reg <= in_range;
        end
        if (out_load)
        begin
            clicks_reg <= reported;
            any_reg    <= any_next;
            active_reg <= active_next;
        end
    end

    renc_state_mem #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .IDX_W        (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (evt_accept),
        .rd_addr  (idx_ext[IDX_W-1:0]),
        .rd_entry (cur_entry),
        .wr_en    (wr_en),
        .wr_addr  (addr_reg),
        .wr_entry (new_entry)
    );

    renc_update u_update (
        .kind      (kind_reg),
        .level_a   (a_reg),
        .level_b   (b_reg),
        .in_range  (in_range_reg),
        .cur_entry (cur_entry),
        .new_entry (new_entry),
        .reported  (reported)
    );

    renc_scan #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .IDX_W        (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (addr_reg),
        .wr_nonzero  (new_entry.clicks != 0),
        .any_next    (any_next),
        .active_next (active_next)
    );

    assign res_valid      = res_valid_reg;
    assign encoder_clicks = clicks_reg;
    assign any_active     = any_reg;
    assign active_index   = active_reg;

endmodule

// ----- sv/renc_state_mem.sv -----
// Per-encoder state memory with registered read and per-entry valid bits
`timescale 1ns / 1ps

module renc_state_mem #(
    parameter int NUM_ENCODERS = renc_pkg::NUM_ENCODERS_DEF,
    parameter int IDX_W        = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output renc_pkg::entry_t     rd_entry,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  renc_pkg::entry_t     wr_entry
);

    renc_pkg::entry_t            entry_mem [NUM_ENCODERS];
    renc_pkg::entry_t            rd_data_reg;
    logic [NUM_ENCODERS-1:0]     valid_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as reset state
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- sv/renc_update.sv -----
// Detent rule and take step applied to one encoder entry
`timescale 1ns / 1ps

module renc_update (
    input  logic                                   kind,
    input  logic                                   level_a,
    input  logic                                   level_b,
    input  logic                                   in_range,
    input  renc_pkg::entry_t                       cur_entry,
    output renc_pkg::entry_t                       new_entry,
    output logic signed [renc_pkg::CLICK_W-1:0]    reported
);

    logic signed [renc_pkg::CLICK_W-1:0] detent_clicks;

    always_comb
    begin
        unique case (cur_entry.dir)
            renc_pkg::DIR_UP:
            begin
                detent_clicks = (cur_entry.clicks == renc_pkg::CLICK_MAX) ?
                                cur_entry.clicks : cur_entry.clicks + 8'sd1;
            end
            renc_pkg::DIR_DOWN:
            begin
                detent_clicks = (cur_entry.clicks == renc_pkg::CLICK_MIN) ?
                                cur_entry.clicks : cur_entry.clicks - 8'sd1;
            end
            default:
            begin
                detent_clicks = cur_entry.clicks;
            end
        endcase
    end

    always_comb
    begin
        new_entry = cur_entry;
        reported  = '0;
        if (in_range)
        begin
            if (kind == renc_pkg::KIND_SAMPLE)
            begin
                if (level_a && level_b)
                begin
                    if (cur_entry.turning)
                    begin
                        new_entry.clicks = detent_clicks;
                    end
                    new_entry.turning = 1'b0;
                    new_entry.dir     = renc_pkg::DIR_NONE;
                end
                else if (!level_a && !level_b)
                begin
                    new_entry.turning = 1'b1;
                end
                else if (!cur_entry.turning)
                begin
                    new_entry.dir = level_a ? renc_pkg::DIR_UP : renc_pkg::DIR_DOWN;
                end
                reported = new_entry.clicks;
            end
            else
            begin
                reported = cur_entry.clicks;
                if (cur_entry.clicks < 0)
                begin
                    new_entry.clicks = cur_entry.clicks + 8'sd1;
                end
                else if (cur_entry.clicks > 0)
                begin
                    new_entry.clicks = cur_entry.clicks - 8'sd1;
                end
            end
        end
    end

endmodule

// ----- sv/renc_scan.sv -----
// Nonzero-click flags per encoder and lowest-active-index search
`timescale 1ns / 1ps

module renc_scan #(
    parameter int NUM_ENCODERS = renc_pkg::NUM_ENCODERS_DEF,
    parameter int IDX_W        = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic                           wr_nonzero,
    output logic                           any_next,
    output logic [renc_pkg::INDEX_W-1:0]   active_next
);

    localparam int EW = IDX_W + renc_pkg::INDEX_W;

    logic [NUM_ENCODERS-1:0] nz_reg;
    logic [NUM_ENCODERS-1:0] nz_next;
    logic [IDX_W-1:0]        low_idx;
    logic [EW-1:0]           low_idx_ext;

    always_comb
    begin
        nz_next = nz_reg;
        if (wr_en)
        begin
            nz_next[wr_addr] = wr_nonzero;
        end
    end

    always_comb
    begin
        low_idx = '0;
        for (int i = NUM_ENCODERS - 1; i >= 0; i--)
        begin
            if (nz_next[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign any_next    = |nz_next;
    assign low_idx_ext = EW'(low_idx);
    assign active_next = low_idx_ext[renc_pkg::INDEX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else
        begin
            nz_reg <= nz_next;
        end
    end

endmodule

// ----- sv/renc_checker.sv -----
// Port-level checks for the rotary encoder detent bank, bound to the top level
`timescale 1ns / 1ps

module renc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  evt_valid,
    input logic                                  evt_stall,
    input logic                                  res_valid,
    input logic                                  res_stall,
    input logic signed [renc_pkg::CLICK_W-1:0]   encoder_clicks,
    input logic                                  any_active,
    input logic [renc_pkg::INDEX_W-1:0]          active_index
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(encoder_clicks)
            && $stable(any_active) && $stable(active_index))
        else $error("stalled result beat changed");

    // block further events while one is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall |=> evt_stall)
        else $error("event taken while previous one still in flight");

    // deliver a result after the read and modify steps of an event when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && !res_valid |=> ##1 res_valid)
        else $error("result missing after event");

    // report index zero when no encoder is active
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !any_active |-> active_index == '0)
        else $error("active index set with no active encoder");

endmodule

bind rotary_encoder_detent_bank renc_checker u_renc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt_valid      (evt_valid),
    .evt_stall      (evt_stall),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .encoder_clicks (encoder_clicks),
    .any_active     (any_active),
    .active_index   (active_index)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the rotary encoder detent bank
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                         kind;
        logic [renc_pkg::INDEX_W-1:0] idx;
        logic                         lvl_a;
        logic                         lvl_b;
    } enc_event_t;

    typedef struct packed {
        logic signed [renc_pkg::CLICK_W-1:0] clicks;
        logic                                any;
        logic [renc_pkg::INDEX_W-1:0]        lowest;
    } click_report_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                evt_valid = 1'b0;
    logic                                evt_stall;
    logic                                kind = renc_pkg::KIND_SAMPLE;
    logic [renc_pkg::INDEX_W-1:0]        encoder_index = '0;
    logic                                level_a = 1'b0;
    logic                                level_b = 1'b0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic signed [renc_pkg::CLICK_W-1:0] encoder_clicks;
    logic                                any_active;
    logic [renc_pkg::INDEX_W-1:0]        active_index;

    renc_pkg::entry_t bank_model [renc_pkg::NUM_ENCODERS_DEF];
    enc_event_t       pending_events [$];
    click_report_t    expected_reports [$];
    int               events_planned = 0;
    int               events_taken = 0;
    int               mismatches = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    logic [15:0]      stall_pattern = '0;
    logic [3:0]       stall_phase = '0;

    rotary_encoder_detent_bank DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_valid      (evt_valid),
        .evt_stall      (evt_stall),
        .kind           (kind),
        .encoder_index  (encoder_index),
        .level_a        (level_a),
        .level_b        (level_b),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .encoder_clicks (encoder_clicks),
        .any_active     (any_active),
        .active_index   (active_index)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic predict_report(input enc_event_t ev);
        click_report_t    rep;
        renc_pkg::entry_t ent;
        int               i;
        ent = bank_model[ev.idx];
        rep = '0;
        if (ev.kind == renc_pkg::KIND_SAMPLE)
        begin
            if (ev.lvl_a && ev.lvl_b)
            begin
                if (ent.turning)
                begin
                    if (ent.dir == renc_pkg::DIR_UP && ent.clicks != renc_pkg::CLICK_MAX)
                        ent.clicks = ent.clicks + 8'sd1;
                    else if (ent.dir == renc_pkg::DIR_DOWN
                             && ent.clicks != renc_pkg::CLICK_MIN)
                        ent.clicks = ent.clicks - 8'sd1;
                end
                ent.turning = 1'b0;
                ent.dir     = renc_pkg::DIR_NONE;
            end
            else if (!ev.lvl_a && !ev.lvl_b)
                ent.turning = 1'b1;
            else if (!ent.turning)
                ent.dir = ev.lvl_a ? renc_pkg::DIR_UP : renc_pkg::DIR_DOWN;
            rep.clicks = ent.clicks;
        end
        else
        begin
            rep.clicks = ent.clicks;
            if (ent.clicks < 0)
                ent.clicks = ent.clicks + 8'sd1;
            else if (ent.clicks > 0)
                ent.clicks = ent.clicks - 8'sd1;
        end
        bank_model[ev.idx] = ent;
        for (i = renc_pkg::NUM_ENCODERS_DEF - 1; i >= 0; i--)
        begin
            if (bank_model[i].clicks != 0)
            begin
                rep.any    = 1'b1;
                rep.lowest = i[renc_pkg::INDEX_W-1:0];
            end
        end
        expected_reports.push_back(rep);
    endtask

    task automatic push_event(input logic k, input int idx, input logic a, input logic b);
        enc_event_t ev;
        ev.kind  = k;
        ev.idx   = idx[renc_pkg::INDEX_W-1:0];
        ev.lvl_a = a;
        ev.lvl_b = b;
        pending_events.push_back(ev);
        events_planned++;
    endtask

    task automatic push_click(input int idx, input logic up);
        if ($urandom_range(0, 3) == 0)
            push_event(renc_pkg::KIND_SAMPLE, idx, !up, up);
        push_event(renc_pkg::KIND_SAMPLE, idx, up, !up);
        push_event(renc_pkg::KIND_SAMPLE, idx, 1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0)
            push_event(renc_pkg::KIND_SAMPLE, idx, !up, up);
        push_event(renc_pkg::KIND_SAMPLE, idx, 1'b1, 1'b1);
    endtask

    task automatic push_mixed(input int target);
        int pick;
        while (events_planned < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                push_click($urandom_range(0, 7), 1'($urandom_range(0, 1)));
            else if (pick < 17)
                push_event(renc_pkg::KIND_TAKE, $urandom_range(0, 7),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                push_event(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic push_saturating_run(input int idx, input logic up);
        repeat (140)
        begin
            push_click(idx, up);
            if ($urandom_range(0, 9) == 0)
                push_event(renc_pkg::KIND_TAKE, (idx + $urandom_range(1, 7)) % 8,
                           1'b0, 1'b0);
        end
        repeat (131)
            push_event(renc_pkg::KIND_TAKE, idx,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        for (int i = 0; i < renc_pkg::NUM_ENCODERS_DEF; i++)
            bank_model[i] = '0;

        // Directed: idle bank, detents without turning, both directions, ignored bounce
        push_event(renc_pkg::KIND_TAKE, 0, 1'b0, 1'b0);
        push_event(renc_pkg::KIND_TAKE, 7, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 3, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 0, 1'b1, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 0, 1'b0, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 0, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 7, 1'b0, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 7, 1'b0, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 7, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_TAKE, 7, 1'b0, 1'b1);
        push_event(renc_pkg::KIND_TAKE, 0, 1'b1, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 5, 1'b0, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 5, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 2, 1'b1, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 2, 1'b0, 1'b0);
        push_event(renc_pkg::KIND_SAMPLE, 2, 1'b0, 1'b1);
        push_event(renc_pkg::KIND_SAMPLE, 2, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_TAKE, 2, 1'b1, 1'b1);
        push_event(renc_pkg::KIND_TAKE, 2, 1'b0, 1'b0);

        // Random: mixed traffic with a run into each saturation limit, then drain
        push_mixed(400);
        push_saturating_run($urandom_range(0, 7), 1'b1);
        push_mixed(1300);
        push_saturating_run($urandom_range(0, 7), 1'b0);
        push_mixed(1850);

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (events_taken < events_planned)
            @(posedge clk);
        while (expected_reports.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid     <= 1'b0;
            kind          <= renc_pkg::KIND_SAMPLE;
            encoder_index <= '0;
            level_a       <= 1'b0;
            level_b       <= 1'b0;
            burst_left    = 0;
            gap_left      = 0;
        end
        else if (!evt_valid || !evt_stall)
        begin
            if (evt_valid)
            begin
                predict_report('{kind, encoder_index, level_a, level_b});
                events_taken++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                evt_valid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                evt_valid     <= 1'b1;
                kind          <= pending_events[0].kind;
                encoder_index <= pending_events[0].idx;
                level_a       <= pending_events[0].lvl_a;
                level_b       <= pending_events[0].lvl_b;
                void'(pending_events.pop_front());
                if (burst_left <= 1)
                begin
                    // long bursts give stretches with no gaps at all
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
                else
                    burst_left--;
            end
            else
                evt_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall     <= 1'b0;
            stall_pattern = '0;
            stall_phase   = '0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat: clicks %0d any %0b index %0d",
                                 $realtime, encoder_clicks, any_active, active_index);
                    mismatches++;
                end
                else
                begin
                    if (encoder_clicks !== expected_reports[0].clicks
                        || any_active !== expected_reports[0].any
                        || active_index !== expected_reports[0].lowest)
                    begin
                        if (mismatches < 10)
                            $display("%0t: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                                     $realtime, expected_reports[0].clicks,
                                     expected_reports[0].any, expected_reports[0].lowest,
                                     encoder_clicks, any_active, active_index);
                        mismatches++;
                    end
                    void'(expected_reports.pop_front());
                end
            end
            if (stall_phase == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'h0000;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'hFFF0;
                    default: stall_pattern = 16'($urandom) & 16'($urandom);
                endcase
            end
            res_stall   <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

endmodule

// ----- sim.f -----
sv/renc_pkg.sv
sv/renc_state_mem.sv
sv/renc_update.sv
sv/renc_scan.sv
sv/rotary_encoder_detent_bank.sv
sv/renc_checker.sv
sim/tb_top.sv
